FILE: hdl/cfr_pkg.sv
// Shared types, constants and helpers for the continued-fraction rationalizer.
// Depends on nothing; used by every module under hdl.
package cfr_pkg;

  localparam int unsigned DIV_W         = 64;
  localparam int unsigned LIM_W         = 32;
  localparam int unsigned CONV_W        = LIM_W + 1;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned MAX_TERMS_DEF = 30;
  localparam int unsigned FRAC_BITS_DEF = 32;

  localparam logic [LIM_W-1:0]  DEFAULT_LIMIT = LIM_W'(1000000);
  localparam logic [CONV_W-1:0] CONV_BIG      = {1'b1, {LIM_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_MAX = 1'b0,
    REG_DEN_MAX = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DWAIT,
    ST_MH,
    ST_MK,
    ST_ML,
    ST_MHI,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturate a quotient to 2^32; bit 32 set means "too large for any limit".
  function automatic logic [CONV_W-1:0] sat_conv(input logic [DIV_W-1:0] x);
    logic [CONV_W-1:0] res;
    if (x[DIV_W-1:LIM_W] != '0) begin
      res = CONV_BIG;
    end else begin
      res = {1'b0, x[LIM_W-1:0]};
    end
    return res;
  endfunction

  // a*h + h2 with saturation at 2^32; prod is the 32x32 product of the low halves.
  function automatic logic [CONV_W-1:0] conv_mac(input logic [2*LIM_W-1:0] prod,
                                                 input logic [CONV_W-1:0]  a,
                                                 input logic [CONV_W-1:0]  h,
                                                 input logic [CONV_W-1:0]  h2);
    logic              big;
    logic [LIM_W+1:0]  sum;
    logic [CONV_W-1:0] res;
    big = (a[LIM_W] && (h != '0)) || (h[LIM_W] && (a != '0)) ||
          (prod[2*LIM_W-1:LIM_W] != '0);
    sum = {2'b00, prod[LIM_W-1:0]} + {1'b0, h2};
    if (big || (sum[LIM_W+1:LIM_W] != 2'b00)) begin
      res = CONV_BIG;
    end else begin
      res = sum[CONV_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/continued_fraction_rationalizer_core.sv
// Continued-fraction rationalizer: turns |value| (Q31.32) into numerator/denominator.
// Top level; depends on cfr_pkg, cfr_div and cfr_mul.
//
// One transaction at a time: in_stall is low only while the core is idle. Each
// continued-fraction term runs a divider start, the bit-serial divide steps and a
// wait for the divider's done flag, passes through the shared 32x32 multiplier for
// the two convergent terms and the two halves of the cutoff product, and an
// update; an item runs at most MAX_TERMS terms. A finished result sits in the
// output register, so the next item is taken while it waits to be read. The
// limit registers are to be written only while idle; the core does not enforce
// it. A value of zero selects 1000000.
module continued_fraction_rationalizer_core #(
  parameter int unsigned MAX_TERMS     = cfr_pkg::MAX_TERMS_DEF,
  parameter int unsigned FRACTION_BITS = cfr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [cfr_pkg::DIV_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cfr_pkg::LIM_W-1:0]       out_numerator,
  output logic [cfr_pkg::LIM_W-1:0]       out_denominator,
  input  logic                            cfg_we,
  input  logic [cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfr_pkg::LIM_W-1:0]       cfg_wdata
);

  localparam int unsigned TW = $clog2(MAX_TERMS + 1);
  localparam int unsigned DW = cfr_pkg::DIV_W;
  localparam int unsigned LW = cfr_pkg::LIM_W;
  localparam int unsigned CVW = cfr_pkg::CONV_W;

  cfr_pkg::state_t    state_r;
  cfr_pkg::state_t    state_nxt;
  cfr_pkg::div_stat_t div_stat;

  logic [LW-1:0]   nmax_r;
  logic [LW-1:0]   dmax_r;
  logic [LW-1:0]   nmax_eff;
  logic [LW-1:0]   dmax_eff;

  logic [DW-1:0]   p_r;
  logic [DW-1:0]   q_r;
  logic [DW-1:0]   r_r;
  logic [CVW-1:0]  a_r;
  logic [CVW-1:0]  h_r;
  logic [CVW-1:0]  k_r;
  logic [CVW-1:0]  h1_r;
  logic [CVW-1:0]  h2_r;
  logic [CVW-1:0]  k1_r;
  logic [CVW-1:0]  k2_r;
  logic [2*LW-1:0] lo_r;
  logic [LW-1:0]   best_n_r;
  logic [LW-1:0]   best_d_r;
  logic [LW-1:0]   best_n_nxt;
  logic [LW-1:0]   best_d_nxt;
  logic [TW-1:0]   term_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [LW-1:0]   out_num_r;
  logic [LW-1:0]   out_den_r;

  logic            div_start;
  logic [DW-1:0]   div_quo;
  logic [DW-1:0]   div_rem;
  logic [LW-1:0]   mul_a;
  logic [LW-1:0]   mul_b;
  logic [2*LW-1:0] mul_prod;

  logic [DW-1:0]     mag;
  logic [3*LW-1:0]   cut_prod;
  logic              cut;
  logic              fits;
  logic              stop;
  logic              out_free;

  assign nmax_eff = (nmax_r == '0) ? cfr_pkg::DEFAULT_LIMIT : nmax_r;
  assign dmax_eff = (dmax_r == '0) ? cfr_pkg::DEFAULT_LIMIT : dmax_r;

  assign mag = in_value[DW-1] ? (~unsigned'(in_value) + DW'(1)) : unsigned'(in_value);

  // d*r from two partial products; stop when 2*d*r < q, r is zero or the last term is reached
  assign cut_prod = {mul_prod, {LW{1'b0}}} + {{LW{1'b0}}, lo_r};
  assign cut      = {cut_prod, 1'b0} < {{(3*LW+1-DW){1'b0}}, q_r};
  assign fits     = (h_r <= {1'b0, nmax_eff}) && (k_r <= {1'b0, dmax_eff});
  assign stop     = (r_r == '0) || cut || (term_r == TW'(MAX_TERMS - 1));
  assign out_free = !out_valid_r || !out_stall;

  cfr_div #(
    .W(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (p_r),
    .divisor  (q_r),
    .stat     (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  cfr_mul u_mul (
    .clk (clk),
    .op_a(mul_a),
    .op_b(mul_b),
    .prod(mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmax_r <= cfr_pkg::DEFAULT_LIMIT;
      dmax_r <= cfr_pkg::DEFAULT_LIMIT;
    end else if (cfg_we) begin
      case (cfr_pkg::cfg_reg_t'(cfg_index))
        cfr_pkg::REG_NUM_MAX: nmax_r <= cfg_wdata;
        cfr_pkg::REG_DEN_MAX: dmax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cfr_pkg::ST_DSTART;
        end
      end
      cfr_pkg::ST_DSTART: state_nxt = cfr_pkg::ST_DWAIT;
      cfr_pkg::ST_DWAIT: begin
        if (div_stat.done) begin
          state_nxt = cfr_pkg::ST_MH;
        end
      end
      cfr_pkg::ST_MH:  state_nxt = cfr_pkg::ST_MK;
      cfr_pkg::ST_MK:  state_nxt = cfr_pkg::ST_ML;
      cfr_pkg::ST_ML:  state_nxt = cfr_pkg::ST_MHI;
      cfr_pkg::ST_MHI: state_nxt = cfr_pkg::ST_UPD;
      cfr_pkg::ST_UPD: begin
        state_nxt = stop ? cfr_pkg::ST_DONE : cfr_pkg::ST_DSTART;
      end
      cfr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != cfr_pkg::ST_IDLE;
    div_start = state_r == cfr_pkg::ST_DSTART;
    mul_a     = a_r[LW-1:0];
    mul_b     = h1_r[LW-1:0];
    case (state_r)
      cfr_pkg::ST_MH: begin
        mul_a = a_r[LW-1:0];
        mul_b = h1_r[LW-1:0];
      end
      cfr_pkg::ST_MK: begin
        mul_a = a_r[LW-1:0];
        mul_b = k1_r[LW-1:0];
      end
      cfr_pkg::ST_ML: begin
        mul_a = dmax_eff;
        mul_b = r_r[LW-1:0];
      end
      cfr_pkg::ST_MHI: begin
        mul_a = dmax_eff;
        mul_b = r_r[DW-1:LW];
      end
      default: ;
    endcase
  end

  always_comb begin
    best_n_nxt = best_n_r;
    best_d_nxt = best_d_r;
    if (term_r == '0) begin
      best_n_nxt = a_r[LW] ? {LW{1'b1}} : a_r[LW-1:0];
      best_d_nxt = LW'(1);
    end
    if (fits) begin
      best_n_nxt = h_r[LW-1:0];
      best_d_nxt = k_r[LW-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == cfr_pkg::ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      term_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if ((state_r == cfr_pkg::ST_IDLE) && in_valid) begin
        term_r <= '0;
      end else if ((state_r == cfr_pkg::ST_UPD) && !stop) begin
        term_r <= term_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          p_r  <= mag;
          q_r  <= DW'(1) << FRACTION_BITS;
          h1_r <= CVW'(1);
          h2_r <= '0;
          k1_r <= '0;
          k2_r <= CVW'(1);
        end
      end
      cfr_pkg::ST_DWAIT: begin
        if (div_stat.done) begin
          a_r <= cfr_pkg::sat_conv(div_quo);
          r_r <= div_rem;
        end
      end
      cfr_pkg::ST_MK:  h_r  <= cfr_pkg::conv_mac(mul_prod, a_r, h1_r, h2_r);
      cfr_pkg::ST_ML:  k_r  <= cfr_pkg::conv_mac(mul_prod, a_r, k1_r, k2_r);
      cfr_pkg::ST_MHI: lo_r <= mul_prod;
      cfr_pkg::ST_UPD: begin
        best_n_r <= best_n_nxt;
        best_d_r <= best_d_nxt;
        h2_r     <= h1_r;
        h1_r     <= h_r;
        k2_r     <= k1_r;
        k1_r     <= k_r;
        p_r      <= q_r;
        q_r      <= r_r;
      end
      cfr_pkg::ST_DONE: begin
        if (out_free) begin
          out_num_r <= best_n_r;
          out_den_r <= best_d_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (q_r != '0))
    else $error("division by zero issued");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cfr_pkg::ST_IDLE) |-> (term_r <= TW'(MAX_TERMS - 1)))
    else $error("term counter past limit");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_denominator != '0))
    else $error("zero denominator delivered");

endmodule

FILE: hdl/cfr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on cfr_pkg for the status struct and default width.
module cfr_div #(
  parameter int unsigned W = cfr_pkg::DIV_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output cfr_pkg::div_stat_t stat,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic          last;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};
  assign last  = cnt_r == CW'(W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/cfr_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on cfr_pkg for the operand width.
module cfr_mul (
  input  logic                        clk,
  input  logic [cfr_pkg::LIM_W-1:0]   op_a,
  input  logic [cfr_pkg::LIM_W-1:0]   op_b,
  output logic [2*cfr_pkg::LIM_W-1:0] prod
);

  logic [2*cfr_pkg::LIM_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
